// File: sv/brf_pkg.sv
package brf_pkg;

    localparam int DEPTH   = 1024;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int USED_W  = 11;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [STAT_W-1:0]  t_status;
    typedef logic [USED_W-1:0]  t_used;
    typedef logic [PTR_W-1:0]   t_ptr;

    localparam t_op OP_BURST = 2'd0;
    localparam t_op OP_WBYTE = 2'd1;
    localparam t_op OP_READ  = 2'd2;
    localparam t_op OP_CLEAR = 2'd3;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_LONG    = 3'd1;
    localparam t_status ST_NOSPACE = 3'd2;
    localparam t_status ST_EMPTY   = 3'd3;
    localparam t_status ST_DROP    = 3'd4;

    typedef struct packed {
        t_op  op;
        logic too_long;
        logic no_space;
        logic burst_open;
        logic full;
        logic empty;
    } t_dp_stat;

    typedef struct packed {
        logic    capture;
        logic    go;
        logic    wr;
        logic    rd;
        logic    set_ovf;
        logic    clr_ovf;
        logic    ld_burst;
        t_status status;
    } t_dp_cmd;

endpackage

// File: sv/brf_if.sv
interface brf_in_if;
    logic            valid;
    logic            ready;
    brf_pkg::t_op    op;
    brf_pkg::t_data  data;
    brf_pkg::t_count count;

    modport source (output valid, output op, output data, output count, input ready);
    modport sink   (input valid, input op, input data, input count, output ready);
endinterface

interface brf_out_if;
    logic             valid;
    logic             ready;
    brf_pkg::t_status status;
    brf_pkg::t_data   read_data;
    brf_pkg::t_used   used;
    logic             overflow;

    modport source (output valid, output status, output read_data, output used,
                    output overflow, input ready);
    modport sink   (input valid, input status, input read_data, input used,
                    input overflow, output ready);
endinterface

// File: sv/byte_ring_fifo_burst_write.sv
// an accepted request is held in the request registers and executed in S_EXEC once the output register is free;
// a new request is taken only after the previous one has executed and its result is registered
// a request is taken while the previous result still waits in the output register
// reset: synchronous, active low; clears pointers, open burst and overflow flag
// the byte store has no reset and no clearing pass
module byte_ring_fifo_burst_write (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brf_in_if.sink    i_in,
    brf_out_if.source o_out
);
    import brf_pkg::*;

    t_dp_stat stat;
    t_dp_cmd  cmd;

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    brf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_in.op),
        .i_data      (i_in.data),
        .i_count     (i_in.count),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_status    (o_out.status),
        .o_read_data (o_out.read_data),
        .o_used      (o_out.used),
        .o_overflow  (o_out.overflow)
    );

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.used <= t_used'(DEPTH - 1)))
        else $error("used count beyond capacity");

    a_empty_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_EMPTY) |-> (o_out.used == '0))
        else $error("empty read with bytes held");

    a_nospace_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.set_ovf |=> (o_out.valid && o_out.overflow && o_out.status == ST_NOSPACE))
        else $error("refused burst did not raise overflow");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr, cmd.rd, cmd.set_ovf, cmd.clr_ovf, cmd.ld_burst}))
        else $error("conflicting datapath commands");
`endif

endmodule

// File: sv/brf_ctrl.sv
module brf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  brf_pkg::t_dp_stat i_stat,
    output brf_pkg::t_dp_cmd  o_cmd
);
    import brf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   capture, go;

    assign o_in_ready  = (r_state == S_IDLE);
    assign capture     = i_in_valid && o_in_ready;
    assign go          = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (capture) n_state = S_EXEC;
            S_EXEC: if (go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = capture;
        o_cmd.go       = go;
        o_cmd.status   = ST_OK;
        unique case (i_stat.op)
            OP_BURST: begin
                if (i_stat.too_long) begin
                    o_cmd.status = ST_LONG;
                end else if (i_stat.no_space) begin
                    o_cmd.status  = ST_NOSPACE;
                    o_cmd.set_ovf = go;
                end else begin
                    o_cmd.ld_burst = go;
                end
            end
            OP_WBYTE: begin
                if (!i_stat.burst_open || i_stat.full) begin
                    o_cmd.status = ST_DROP;
                end else begin
                    o_cmd.wr = go;
                end
            end
            OP_READ: begin
                if (i_stat.empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.rd = go;
                end
            end
            OP_CLEAR: o_cmd.clr_ovf = go;
            default: o_cmd.status = ST_OK;
        endcase
    end

endmodule

// File: sv/brf_dp.sv
module brf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brf_pkg::t_op      i_op,
    input  brf_pkg::t_data    i_data,
    input  brf_pkg::t_count   i_count,
    input  brf_pkg::t_dp_cmd  i_cmd,
    output brf_pkg::t_dp_stat o_stat,
    output brf_pkg::t_status  o_status,
    output brf_pkg::t_data    o_read_data,
    output brf_pkg::t_used    o_used,
    output logic              o_overflow
);
    import brf_pkg::*;

    t_data  mem [DEPTH];
    t_data  r_rd_q;
    t_ptr   r_head, r_tail;
    t_count r_burst;
    logic   r_ovf;
    t_op    r_op;
    t_data  r_data;
    t_count r_count;
    t_used  used, space, used_next;

    assign used      = t_used'(t_ptr'(r_head - r_tail));
    assign space     = t_used'(DEPTH - 1) - used;
    assign used_next = used + t_used'(i_cmd.wr) - t_used'(i_cmd.rd);

    always_comb begin
        o_stat.op         = r_op;
        o_stat.too_long   = (r_count >= t_count'(DEPTH));
        o_stat.no_space   = (r_count > t_count'(space));
        o_stat.burst_open = (r_burst != '0);
        o_stat.full       = (used >= t_used'(DEPTH - 1));
        o_stat.empty      = (used == '0);
    end

    // store, read port always aimed at the tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_head] <= r_data;
        end
        if (i_cmd.capture) begin
            r_rd_q <= mem[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_data  <= i_data;
            r_count <= i_count;
        end
        if (i_cmd.go) begin
            o_status    <= i_cmd.status;
            o_read_data <= i_cmd.rd ? r_rd_q : '0;
            o_used      <= used_next;
            o_overflow  <= i_cmd.set_ovf ? 1'b1 : (i_cmd.clr_ovf ? 1'b0 : r_ovf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_burst <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_head  <= r_head + t_ptr'(1);
                r_burst <= r_burst - t_count'(1);
            end else if (i_cmd.ld_burst) begin
                r_burst <= r_count;
            end
            if (i_cmd.rd) begin
                r_tail <= r_tail + t_ptr'(1);
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end else if (i_cmd.clr_ovf) begin
                r_ovf <= 1'b0;
            end
        end
    end

endmodule

// File: tb/brf_fifo_checker.sv
`timescale 1ns / 1ps

module brf_fifo_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    brf_in_if    i_req,
    brf_out_if   i_rsp,
    output int   o_pending,
    output int   o_mismatch_count
);
    import brf_pkg::*;

    typedef struct packed {
        t_status status;
        t_data   read_data;
        t_used   used;
        logic    overflow;
    } t_fifo_result;

    logic [DATA_W-1:0] ring_bytes [DEPTH];
    t_ptr              wr_ptr = '0;
    t_ptr              rd_ptr = '0;
    t_count            bytes_left = '0;
    logic              ovf_flag = 1'b0;

    t_fifo_result expected_results [$];
    t_fifo_result want;
    int           pending_depth = 0;
    int           mismatch_count = 0;

    assign o_pending        = pending_depth;
    assign o_mismatch_count = mismatch_count;

    task automatic report_mismatch(string what, int unsigned want_val, int unsigned got_val);
        $display("%0t mismatch on %s: expected %0h got %0h", $realtime, what, want_val, got_val);
        mismatch_count++;
    endtask

    function automatic t_fifo_result fifo_apply(t_op op, t_data data, t_count count);
        t_fifo_result r;
        int unsigned  held;
        held = int'(t_ptr'(wr_ptr - rd_ptr));
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_BURST: begin
                if (int'(count) >= DEPTH) begin
                    r.status = ST_LONG;
                end else if (int'(count) > DEPTH - 1 - held) begin
                    ovf_flag = 1'b1;
                    r.status = ST_NOSPACE;
                end else begin
                    bytes_left = count;
                end
            end
            OP_WBYTE: begin
                if (bytes_left == 0 || held >= DEPTH - 1) begin
                    r.status = ST_DROP;
                end else begin
                    ring_bytes[wr_ptr] = data;
                    wr_ptr++;
                    bytes_left--;
                end
            end
            OP_READ: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_data = ring_bytes[rd_ptr];
                    rd_ptr++;
                end
            end
            default: begin
                ovf_flag = 1'b0;
            end
        endcase
        r.used     = t_used'(t_ptr'(wr_ptr - rd_ptr));
        r.overflow = ovf_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr     = '0;
            rd_ptr     = '0;
            bytes_left = '0;
            ovf_flag   = 1'b0;
            expected_results.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 0, i_rsp.status);
                end else begin
                    want = expected_results.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", want.status, i_rsp.status);
                    if (i_rsp.read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, i_rsp.read_data);
                    if (i_rsp.used !== want.used)
                        report_mismatch("used", want.used, i_rsp.used);
                    if (i_rsp.overflow !== want.overflow)
                        report_mismatch("overflow", want.overflow, i_rsp.overflow);
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                expected_results.push_back(fifo_apply(i_req.op, i_req.data, i_req.count));
        end
        pending_depth <= expected_results.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import brf_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brf_in_if  req_ch ();
    brf_out_if rsp_ch ();

    int    pending_results;
    int    mismatch_count;
    int    items_sent = 0;
    int    op_count [4] = '{0, 0, 0, 0};
    int    fill_bytes = 0;
    int    drain_pauses = 0;
    int    read_mix = 30;
    bit    req_fast = 1'b0;
    bit    rsp_fast = 1'b0;
    int    stall_left = 0;
    t_used last_used = '0;

    byte_ring_fifo_burst_write u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    brf_fifo_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req_ch),
        .i_rsp            (rsp_ch),
        .o_pending        (pending_results),
        .o_mismatch_count (mismatch_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            last_used <= rsp_ch.used;
            if ($urandom_range(0, 59) == 0)
                rsp_fast = !rsp_fast;
            stall_left = rsp_fast ? 0 : $urandom_range(0, 10);
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    initial begin
        #400000;
        $display("byte_ring_fifo_burst_write verification failed");
        $finish;
    end

    task automatic send_req(t_op op, t_data data, t_count count);
        int gap;
        if ($urandom_range(0, 79) == 0)
            req_fast = !req_fast;
        gap = req_fast ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.data  <= data;
        req_ch.count <= count;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        items_sent++;
        op_count[op]++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        drain_pauses++;
    endtask

    function automatic t_data rand_byte();
        return t_data'($urandom_range(0, 255));
    endfunction

    task automatic random_sequence();
        int pick;
        int n;
        int bytes;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            // noise: any op with any fields
            repeat ($urandom_range(1, 5))
                send_req(t_op'($urandom_range(0, 3)), rand_byte(), t_count'($urandom_range(0, 65535)));
        end else if (pick < 16) begin
            send_req(OP_CLEAR, rand_byte(), t_count'($urandom_range(0, 65535)));
        end else if (pick < 28) begin
            repeat ($urandom_range(1, 30))
                send_req(OP_READ, rand_byte(), t_count'($urandom_range(0, 65535)));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n = $urandom_range(0, 24);
            else if (pick < 85)
                n = $urandom_range(25, DEPTH - 1);
            else if (pick < 93)
                n = $urandom_range(DEPTH, 65535);
            else
                n = $urandom_range(0, 65535);
            send_req(OP_BURST, rand_byte(), t_count'(n));
            bytes = (n < 48) ? n : 48;
            // short or overlong bursts now and then
            if ($urandom_range(0, 5) == 0)
                bytes = $urandom_range(0, bytes + 2);
            repeat (bytes) begin
                if ($urandom_range(0, 99) < read_mix)
                    send_req(OP_READ, rand_byte(), t_count'($urandom_range(0, 65535)));
                send_req(OP_WBYTE, rand_byte(), t_count'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin
        int seqs;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_READ;
        req_ch.data  <= '0;
        req_ch.count <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_req(OP_READ,  8'h00, 16'h0000);
        send_req(OP_WBYTE, 8'hFF, 16'hFFFF);
        send_req(OP_CLEAR, 8'h00, 16'h0000);
        send_req(OP_BURST, 8'h00, 16'd1024);
        send_req(OP_BURST, 8'hFF, 16'hFFFF);
        send_req(OP_BURST, 8'h00, 16'd0);
        send_req(OP_WBYTE, 8'h11, 16'h0000);
        send_req(OP_BURST, 8'h00, 16'd3);
        send_req(OP_WBYTE, 8'h00, 16'h0000);
        send_req(OP_WBYTE, 8'hFF, 16'hFFFF);
        send_req(OP_WBYTE, 8'h5A, 16'h0000);
        send_req(OP_WBYTE, 8'h77, 16'h0000);
        send_req(OP_BURST, 8'h00, 16'd1021);
        send_req(OP_READ,  8'h00, 16'h0000);
        send_req(OP_CLEAR, 8'hFF, 16'hFFFF);
        send_req(OP_BURST, 8'h00, 16'd4);
        send_req(OP_WBYTE, 8'hA5, 16'h0000);
        send_req(OP_BURST, 8'h00, 16'd2);
        send_req(OP_WBYTE, 8'h3C, 16'h0000);
        send_req(OP_WBYTE, 8'hC3, 16'h0000);
        send_req(OP_WBYTE, 8'h99, 16'h0000);
        send_req(OP_BURST, 8'h00, 16'd1019);
        send_req(OP_READ,  8'h00, 16'h0000);
        send_req(OP_READ,  8'hFF, 16'hFFFF);

        seqs = 0;
        while (items_sent < 200) begin
            random_sequence();
            seqs++;
        end

        // pause, then fill the store to capacity
        wait_drained();
        fill_bytes = DEPTH - 1 - int'(last_used);
        send_req(OP_BURST, rand_byte(), t_count'(fill_bytes));
        repeat (fill_bytes) send_req(OP_WBYTE, rand_byte(), t_count'($urandom_range(0, 65535)));
        send_req(OP_WBYTE, rand_byte(), 16'h0000);
        send_req(OP_BURST, rand_byte(), 16'd1);
        send_req(OP_BURST, rand_byte(), 16'd0);
        send_req(OP_WBYTE, rand_byte(), 16'h0000);
        send_req(OP_READ,  rand_byte(), 16'h0000);
        send_req(OP_CLEAR, rand_byte(), 16'h0000);

        while (items_sent < 1400) begin
            if (seqs % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0: read_mix = 10;
                    1: read_mix = 40;
                    default: read_mix = 90;
                endcase
            end
            random_sequence();
            seqs++;
            if (seqs % 60 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests: %0d burst starts, %0d byte writes, %0d reads, %0d clears",
                 items_sent, op_count[OP_BURST], op_count[OP_WBYTE], op_count[OP_READ],
                 op_count[OP_CLEAR]);
        $display("including a fill to capacity of %0d bytes and %0d drain pauses",
                 fill_bytes, drain_pauses);
        if (mismatch_count == 0) begin
            $display("byte_ring_fifo_burst_write verification clean");
        end else begin
            $display("byte_ring_fifo_burst_write verification failed");
        end
        $finish;
    end

endmodule
